// ----- hdl/bba_pkg.sv -----
// Shared constants, codes and types of the bitmap block allocator.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package bba_pkg;

    // Geometry of the swap space and of one request
    localparam int NUM_BLOCKS = 1024;
    localparam int MAX_REQ    = 64;

    // Field widths
    localparam int SIZE_W = 24;
    localparam int BS_W   = 13;
    localparam int BLK_W  = 10;
    localparam int ST_W   = 2;

    // Bitmap kept as rows of WORD_W bits
    localparam int WORD_W   = 32;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int NUM_ROWS = NUM_BLOCKS / WORD_W;
    localparam int ROW_W    = $clog2(NUM_ROWS);

    // Counters
    localparam int NEED_W  = $clog2(MAX_REQ + 1);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int DIV_CW  = $clog2(SIZE_W);

    // Command queue between front and back (power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [BS_W-1:0] BS_RESET = BS_W'(64);

    // Input commands
    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_FREE    = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        K_RESERVE,
        K_TOO_LARGE,
        K_FREE,
        K_BAD_INDEX
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [NEED_W-1:0] need;
        logic [BLK_W-1:0]  index;
    } t_cmd;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_rsp;

endpackage

`default_nettype wire

// ----- hdl/bba_ifs.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_req_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [bba_pkg::SIZE_W-1:0]       process_size;
    logic [bba_pkg::BLK_W-1:0]        block_index;

    modport source (output valid, command, process_size, block_index, input ready);
    modport sink   (input valid, command, process_size, block_index, output ready);
endinterface

interface bba_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bba_pkg::BLK_W-1:0]        allocated_block;
    logic [bba_pkg::ST_W-1:0]         status;
    logic                             last;

    modport source (output valid, allocated_block, status, last, input ready);
    modport sink   (input valid, allocated_block, status, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/bitmap_block_allocator_unit.sv -----
// Top level of the bitmap first-fit swap block allocator.
// Depends on bba_pkg, bba_ifs, bba_front, bba_queue and bba_back.
`default_nettype none

// Keeps one used/free bit per swap block (1024 blocks) and a free count.
// A reserve item asks for process_size / block_size + 1 blocks and gets the
// lowest-numbered free ones, one result item per block in ascending order,
// the final one marked last; a request over 64 blocks or over the free count
// gets one result with an error status and changes nothing. A free item
// clears one block and gives one result. All blocks are free straight out of
// reset: per-row valid bits stand in for a clearing pass, so items are taken
// as soon as reset is released. The front end divides the size one quotient
// bit per cycle and then classifies the item; the back end then visits the
// bitmap rows of 32 blocks in turn, loading each row and claiming its free
// blocks one by one, each claim going out as a result. A reserve that is
// rejected still goes through the division. A two-entry queue lets the next
// item be divided while the back end is still claiming; the single result
// register holds a result while it waits, and the back end makes no further
// claim until that result is taken. block_size is written through
// i_cfg_we/i_cfg_data; the user is to write it only while the block is
// idle, which the block itself does not enforce; a value of 0 acts as 1.
module bitmap_block_allocator_unit (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [bba_pkg::BS_W-1:0] i_cfg_data,
    bba_req_if.sink                       i_req,
    bba_rsp_if.source                     o_rsp
);
    import bba_pkg::*;

    logic [BS_W-1:0] r_block_size;
    logic            push_vld;
    logic            push_rdy;
    t_cmd            push_data;
    logic            q_vld;
    logic            q_pop;
    t_cmd            q_data;
    logic            out_vld;
    t_rsp            out_data;

    // Block size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BS_RESET;
        end else if (i_cfg_we) begin
            r_block_size <= i_cfg_data;
        end
    end

    bba_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block_size   (r_block_size),
        .i_in_vld       (i_req.valid),
        .i_command      (i_req.command),
        .i_process_size (i_req.process_size),
        .i_block_index  (i_req.block_index),
        .o_in_rdy       (i_req.ready),
        .o_push_vld     (push_vld),
        .o_push_data    (push_data),
        .i_push_rdy     (push_rdy)
    );

    bba_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (push_vld),
        .i_push_data (push_data),
        .o_push_rdy  (push_rdy),
        .o_pop_vld   (q_vld),
        .o_pop_data  (q_data),
        .i_pop       (q_pop)
    );

    bba_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (q_vld),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_out_vld (out_vld),
        .o_out     (out_data),
        .i_out_rdy (o_rsp.ready)
    );

    // Result channel
    assign o_rsp.valid           = out_vld;
    assign o_rsp.allocated_block = out_data.blk;
    assign o_rsp.status          = out_data.status;
    assign o_rsp.last            = out_data.last;

endmodule

`default_nettype wire

// ----- hdl/bba_front.sv -----
// Front end: accepts request items, divides size by block size bit-serially
// and classifies each item into a command for the back end. Uses bba_pkg.
`default_nettype none

module bba_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [bba_pkg::BS_W-1:0]   i_block_size,
    input  wire logic                       i_in_vld,
    input  wire logic                       i_command,
    input  wire logic [bba_pkg::SIZE_W-1:0] i_process_size,
    input  wire logic [bba_pkg::BLK_W-1:0]  i_block_index,
    output logic                            o_in_rdy,
    output logic                            o_push_vld,
    output bba_pkg::t_cmd                   o_push_data,
    input  wire logic                       i_push_rdy
);
    import bba_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_CLASS, F_PUSH} t_fstate;

    t_fstate           r_state;
    logic [BS_W-1:0]   r_bs;
    logic [BS_W-1:0]   r_rem;
    logic [SIZE_W-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    t_cmd              r_cmd;

    logic [BS_W:0]     n_trial;
    logic              n_qbit;
    logic [BS_W:0]     n_diff;
    logic              accept;

    // One restoring-division step per cycle
    always_comb begin
        n_trial = {r_rem, r_quo[SIZE_W-1]};
        n_diff  = n_trial - {1'b0, r_bs};
        n_qbit  = (n_trial >= {1'b0, r_bs});
    end

    assign accept      = i_in_vld && (r_state == F_IDLE);
    assign o_in_rdy    = (r_state == F_IDLE);
    assign o_push_vld  = (r_state == F_PUSH);
    assign o_push_data = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        if (i_command == CMD_FREE) begin
                            r_cmd.kind  <= (32'(i_block_index) >= NUM_BLOCKS) ?
                                           K_BAD_INDEX : K_FREE;
                            r_cmd.need  <= '0;
                            r_cmd.index <= i_block_index;
                            r_state     <= F_PUSH;
                        end else begin
                            // zero block size behaves as one
                            r_bs    <= (i_block_size == '0) ? BS_W'(1) : i_block_size;
                            r_rem   <= '0;
                            r_quo   <= i_process_size;
                            r_cnt   <= '0;
                            r_state <= F_DIV;
                        end
                    end
                end
                F_DIV: begin
                    r_rem <= n_qbit ? n_diff[BS_W-1:0] : n_trial[BS_W-1:0];
                    r_quo <= {r_quo[SIZE_W-2:0], n_qbit};
                    r_cnt <= r_cnt + DIV_CW'(1);
                    if (r_cnt == DIV_CW'(SIZE_W - 1)) begin
                        r_state <= F_CLASS;
                    end
                end
                F_CLASS: begin
                    // blocks needed = quotient + 1
                    r_cmd.index <= '0;
                    if (r_quo >= SIZE_W'(MAX_REQ)) begin
                        r_cmd.kind <= K_TOO_LARGE;
                        r_cmd.need <= '0;
                    end else begin
                        r_cmd.kind <= K_RESERVE;
                        r_cmd.need <= NEED_W'(r_quo) + NEED_W'(1);
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_push_rdy) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bba_queue.sv -----
// Short command queue that decouples the front end from the back end.
// Depends on bba_pkg for the command type and depth.
`default_nettype none

module bba_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_vld,
    input  wire bba_pkg::t_cmd i_push_data,
    output logic               o_push_rdy,
    output logic               o_pop_vld,
    output bba_pkg::t_cmd      o_pop_data,
    input  wire logic          i_pop
);
    import bba_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_rdy = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rp];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_pop_vld;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + Q_CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - Q_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bba_back.sv -----
// Back end: owns the used/free bitmap (row memory plus row valid bits) and
// the free count, carries out commands and drives the result register. Uses bba_pkg.
`default_nettype none

module bba_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_vld,
    input  wire bba_pkg::t_cmd i_q_data,
    output logic               o_q_pop,
    output logic               o_out_vld,
    output bba_pkg::t_rsp      o_out,
    input  wire logic          i_out_rdy
);
    import bba_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FREE, S_LOAD, S_SCAN, S_EMIT} t_bstate;

    t_bstate            r_state;
    t_cmd               r_cmd;
    t_rsp               r_res;
    t_rsp               r_out;
    logic               r_out_vld;
    logic [CNT_W-1:0]   r_free_cnt;
    logic [ROW_W-1:0]   r_row;
    logic [WORD_W-1:0]  r_word;
    logic               r_dirty;
    logic [NEED_W-1:0]  r_got;

    // Bitmap rows; a row not yet written reads as all free
    logic [WORD_W-1:0]  r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0] r_row_vld;
    logic [WORD_W-1:0]  r_rd_data;
    logic               r_rd_vld;

    logic [ROW_W-1:0]   ra;
    logic               we;
    logic [ROW_W-1:0]   wa;
    logic [WORD_W-1:0]  wd;
    logic [WORD_W-1:0]  word_eff;
    logic [BIT_W-1:0]   fz_bit;
    logic               word_full;
    logic               emit_ok;
    logic               out_load;
    logic               last_claim;
    logic [BIT_W-1:0]   free_bit;

    // Lowest clear bit of the current row
    always_comb begin
        fz_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!r_word[i]) begin
                fz_bit = BIT_W'(i);
            end
        end
    end

    assign word_full  = &r_word;
    assign word_eff   = r_rd_vld ? r_rd_data : '0;
    assign emit_ok    = !r_out_vld || i_out_rdy;
    // result register takes a new item this cycle
    assign out_load   = emit_ok && ((r_state == S_SCAN && !word_full) || (r_state == S_EMIT));
    assign last_claim = ((r_got + NEED_W'(1)) == r_cmd.need);
    assign free_bit   = r_cmd.index[BIT_W-1:0];
    assign o_q_pop    = (r_state == S_IDLE);
    assign o_out_vld  = r_out_vld;
    assign o_out      = r_out;

    // Memory port control
    always_comb begin
        ra = r_row;
        we = 1'b0;
        wa = r_row;
        wd = r_word;
        case (r_state)
            S_IDLE: begin
                ra = (i_q_data.kind == K_FREE) ? i_q_data.index[BIT_W +: ROW_W] : '0;
            end
            S_FREE: begin
                we = word_eff[free_bit];
                wd = word_eff & ~(WORD_W'(1) << free_bit);
            end
            S_SCAN: begin
                if (word_full) begin
                    we = r_dirty;
                    ra = r_row + ROW_W'(1);
                end else if (emit_ok && last_claim) begin
                    we = 1'b1;
                    wd = r_word | (WORD_W'(1) << fz_bit);
                end
            end
            default: begin
                ra = r_row;
            end
        endcase
    end

    // Bitmap row storage with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_data <= r_mem[ra];
    end

    // Command sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_free_cnt <= CNT_W'(NUM_BLOCKS);
            r_row_vld  <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[ra];
            if (we) begin
                r_row_vld[wa] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_vld) begin
                        r_cmd <= i_q_data;
                        r_row <= ra;
                        r_got <= '0;
                        r_dirty <= 1'b0;
                        case (i_q_data.kind)
                            K_FREE: begin
                                r_state <= S_FREE;
                            end
                            K_BAD_INDEX: begin
                                r_res   <= '{blk: '0, status: ST_BAD_INDEX, last: 1'b1};
                                r_state <= S_EMIT;
                            end
                            K_TOO_LARGE: begin
                                r_res   <= '{blk: '0, status: ST_TOO_LARGE, last: 1'b1};
                                r_state <= S_EMIT;
                            end
                            K_RESERVE: begin
                                if (CNT_W'(i_q_data.need) > r_free_cnt) begin
                                    r_res   <= '{blk: '0, status: ST_NO_SPACE, last: 1'b1};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_LOAD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FREE: begin
                    // freeing an already free block changes nothing
                    if (word_eff[free_bit]) begin
                        r_free_cnt <= r_free_cnt + CNT_W'(1);
                    end
                    r_res   <= '{blk: '0, status: ST_OK, last: 1'b1};
                    r_state <= S_EMIT;
                end
                S_LOAD: begin
                    r_word  <= word_eff;
                    r_dirty <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (word_full) begin
                        // row exhausted: move on to the next one
                        r_row   <= r_row + ROW_W'(1);
                        r_state <= S_LOAD;
                    end else if (emit_ok) begin
                        r_word[fz_bit] <= 1'b1;
                        r_dirty        <= 1'b1;
                        r_got          <= r_got + NEED_W'(1);
                        r_free_cnt     <= r_free_cnt - CNT_W'(1);
                        r_out          <= '{blk: {r_row, fz_bit}, status: ST_OK,
                                            last: last_claim};
                        if (last_claim) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_out     <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Free count never exceeds the pool size
    a_free_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CNT_W'(NUM_BLOCKS))
        else $error("free count above pool size");

    // A reserve never claims more blocks than it asked for
    a_got_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_got < r_cmd.need))
        else $error("claim count reached request size during scan");

    // The free count check keeps the scan from running off the last row
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && word_full) |-> (r_row != ROW_W'(NUM_ROWS - 1)))
        else $error("scan ran past the last bitmap row");

    // Each claim lands in the result register as a good item
    a_claim_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !word_full && emit_ok) |=>
        (r_out_vld && r_out.status == ST_OK))
        else $error("claimed block not presented as a result");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for the bitmap first-fit swap block allocator.
// Directed table, then four random phases checked against an in-bench bitmap.
// Depends on bba_pkg, bba_ifs and the bitmap_block_allocator_unit RTL.
`timescale 1ns / 1ps

module tb_top;
    import bba_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int PHASE_ITEMS    = 85;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int REPORT_MAX     = 10;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One line of the directed plan: an item or a block_size write
    typedef struct packed {
        t_row_kind         kind;
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  idx;
        logic [BS_W-1:0]   bs;
        logic              typed;
        t_rsp              want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [BS_W-1:0]   i_cfg_data;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the allocator state
    logic [NUM_BLOCKS-1:0] used_bits;
    int unsigned           free_blocks;
    logic [BS_W-1:0]       blk_bytes;
    t_rsp                  due_results[$];

    // Traffic shaping, set by the main sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_seq   = 0;

    // Tallies
    int mismatch_cnt = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int status_seen [4];

    t_row plan[$];

    // Apply one item to the shadow bitmap; keep selects whether its results are queued
    task automatic allocate_or_free(input logic cmd, input logic [SIZE_W-1:0] size,
                                    input logic [BLK_W-1:0] idx, input bit keep);
        int unsigned bse;
        int unsigned need;
        int unsigned got;
        t_rsp        r;
        bse      = (blk_bytes == '0) ? 1 : int'(blk_bytes);
        r.blk    = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        if (cmd == CMD_FREE) begin
            if (int'(idx) >= NUM_BLOCKS) begin
                r.status = ST_BAD_INDEX;
            end else if (used_bits[idx]) begin
                used_bits[idx] = 1'b0;
                free_blocks++;
            end
            if (keep) due_results.push_back(r);
        end else begin
            need = size / bse + 1;
            if (need > MAX_REQ) begin
                r.status = ST_TOO_LARGE;
                if (keep) due_results.push_back(r);
            end else if (need > free_blocks) begin
                r.status = ST_NO_SPACE;
                if (keep) due_results.push_back(r);
            end else begin
                // first fit from block zero, one result per claimed block
                got = 0;
                for (int b = 0; b < NUM_BLOCKS && got < need; b++) begin
                    if (!used_bits[b]) begin
                        used_bits[b] = 1'b1;
                        r.blk  = BLK_W'(b);
                        r.last = (got + 1 == need);
                        if (keep) due_results.push_back(r);
                        got++;
                    end
                end
                free_blocks -= got;
            end
        end
    endtask

    // Offer one item with an optional idle gap, return once it is taken
    task automatic offer_item(input logic cmd, input logic [SIZE_W-1:0] size,
                              input logic [BLK_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.process_size <= size;
        req_ch.block_index  <= idx;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // block_size is only written with nothing in flight
    task automatic set_block_size(input logic [BS_W-1:0] v);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        blk_bytes = v;
    endtask

    task automatic row_item(input logic cmd, input logic [SIZE_W-1:0] size,
                            input logic [BLK_W-1:0] idx, input logic typed,
                            input logic [BLK_W-1:0] blk, input logic [ST_W-1:0] st);
        t_row r;
        r             = '0;
        r.kind        = ROW_ITEM;
        r.cmd         = cmd;
        r.size        = size;
        r.idx         = idx;
        r.typed       = typed;
        r.want.blk    = blk;
        r.want.status = st;
        r.want.last   = 1'b1;
        plan.push_back(r);
    endtask

    task automatic row_cfg(input logic [BS_W-1:0] v);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.bs   = v;
        plan.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input t_rsp want, input t_rsp got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
            $write("%0t: %s: expected blk=%0d status=%0d last=%0d",
                   $time, what, want.blk, want.status, want.last);
            $display(", got blk=%0d status=%0d last=%0d",
                     got.blk, got.status, got.last);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req_seq) begin
                hold_seen = hold_req_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: compare each taken result with the oldest pending one
    always @(posedge i_clk) begin
        t_rsp got_rsp;
        t_rsp want_rsp;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got_rsp.blk    = rsp_ch.allocated_block;
            got_rsp.status = rsp_ch.status;
            got_rsp.last   = rsp_ch.last;
            results_seen++;
            status_seen[got_rsp.status]++;
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, got_rsp);
            end else begin
                want_rsp = due_results.pop_front();
                if (got_rsp.blk !== want_rsp.blk || got_rsp.status !== want_rsp.status ||
                    got_rsp.last !== want_rsp.last)
                    report_mismatch("wrong result", want_rsp, got_rsp);
            end
        end
    end

    // Hard stop
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  idx;
        logic [BS_W-1:0]   phase_bs [4];
        int                idle_send [4];
        int                idle_recv [4];
        int unsigned       bse;
        int unsigned       need;
        int                roll;
        int                j;
        bit                fill;
        bit                found;

        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_RESERVE;
        req_ch.process_size = '0;
        req_ch.block_index  = '0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;
        foreach (status_seen[s]) status_seen[s] = 0;

        used_bits   = '0;
        free_blocks = NUM_BLOCKS;
        blk_bytes   = BS_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan, starting at the reset block size of 64 bytes
        row_item(CMD_RESERVE, 24'd0,        10'd0,   1, 10'd0, ST_OK);
        row_item(CMD_RESERVE, 24'd63,       10'd0,   1, 10'd1, ST_OK);
        row_item(CMD_RESERVE, 24'd64,       10'd0,   0, '0, ST_OK);
        row_item(CMD_RESERVE, 24'd4095,     10'd0,   0, '0, ST_OK);      // 64 blocks
        row_item(CMD_RESERVE, 24'd4096,     10'd0,   1, 10'd0, ST_TOO_LARGE);
        row_item(CMD_RESERVE, 24'hFFFFFF,   10'd1023, 1, 10'd0, ST_TOO_LARGE);
        row_item(CMD_FREE,    24'hFFFFFF,   10'd0,   1, 10'd0, ST_OK);
        row_item(CMD_FREE,    24'd0,        10'd0,   1, 10'd0, ST_OK);   // already free
        row_item(CMD_RESERVE, 24'd0,        10'd0,   1, 10'd0, ST_OK);   // reuses block 0
        row_item(CMD_FREE,    24'd0,        10'd1023, 1, 10'd0, ST_OK);
        row_item(CMD_FREE,    24'd0,        10'd3,   1, 10'd0, ST_OK);
        row_item(CMD_RESERVE, 24'd127,      10'd0,   0, '0, ST_OK);      // fills the hole first
        row_cfg(13'd0);                                                  // zero acts as one
        row_item(CMD_RESERVE, 24'd63,       10'd0,   0, '0, ST_OK);
        row_item(CMD_RESERVE, 24'd64,       10'd0,   1, 10'd0, ST_TOO_LARGE);
        row_cfg(13'd8191);
        row_item(CMD_RESERVE, 24'd524287,   10'd0,   1, 10'd0, ST_TOO_LARGE);
        row_item(CMD_RESERVE, 24'd524223,   10'd0,   0, '0, ST_OK);
        row_cfg(13'd4096);
        row_item(CMD_FREE,    24'd0,        10'd5,   1, 10'd0, ST_OK);
        row_item(CMD_RESERVE, 24'd0,        10'd0,   0, '0, ST_OK);
        row_item(CMD_FREE,    24'h555555,   10'd682, 1, 10'd0, ST_OK);
        row_item(CMD_FREE,    24'hAAAAAA,   10'd341, 1, 10'd0, ST_OK);
        row_cfg(BS_RESET);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                set_block_size(plan[i].bs);
            end else begin
                offer_item(plan[i].cmd, plan[i].size, plan[i].idx);
                allocate_or_free(plan[i].cmd, plan[i].size, plan[i].idx, !plan[i].typed);
                if (plan[i].typed) due_results.push_back(plan[i].want);
            end
        end

        // Random phases: each with its own block size and traffic pattern
        phase_bs[0] = 13'd1;
        phase_bs[1] = 13'd4096;
        phase_bs[2] = BS_W'($urandom_range(2, 200));
        phase_bs[3] = 13'd0;
        idle_send   = '{0, 80, 0, 38};
        idle_recv   = '{0, 0, 80, 38};

        for (int p = 0; p < 4; p++) begin
            set_block_size(phase_bs[p]);
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            // long receiver hold while large reserves keep coming: input must back up
            if (p == 0) hold_req_seq++;
            bse = (blk_bytes == '0) ? 1 : int'(blk_bytes);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // fill stretches push the map full, drain stretches mostly free
                fill = (n % 40) < 24;
                roll = $urandom_range(0, 99);
                cmd  = CMD_RESERVE;
                size = SIZE_W'($urandom);
                idx  = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
                if (roll < (fill ? 85 : 30)) begin
                    if ($urandom_range(0, 9) != 0) begin
                        need = fill ? $urandom_range(1, MAX_REQ) : $urandom_range(1, 8);
                        size = SIZE_W'((need - 1) * bse + $urandom_range(0, bse - 1));
                    end
                end else begin
                    cmd = CMD_FREE;
                    // usually free a block that is in use, searching up from a random point
                    if ($urandom_range(0, 3) != 0) begin
                        found = 1'b0;
                        for (int k = 0; k < NUM_BLOCKS; k++) begin
                            j = (int'(idx) + k) % NUM_BLOCKS;
                            if (!found && used_bits[j]) begin
                                idx   = BLK_W'(j);
                                found = 1'b1;
                            end
                        end
                    end
                end
                offer_item(cmd, size, idx);
                allocate_or_free(cmd, size, idx, 1'b1);
            end
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d in the directed plan), checked %0d results:",
                 items_sent, plan.size() - 4, results_seen);
        $write("  %0d ok, %0d short of free blocks, %0d too large;",
               status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_TOO_LARGE]);
        $display(" block sizes 0, 1, 64, %0d, 4096, 8191", phase_bs[2]);
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bba_pkg.sv
hdl/bba_ifs.sv
hdl/bba_front.sv
hdl/bba_queue.sv
hdl/bba_back.sv
hdl/bitmap_block_allocator_unit.sv
sim/tb_top.sv
